FILE: rtl/diffusion_stencil_sweep_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the diffusion stencil sweep unit
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIFFUSION_STENCIL_SWEEP_UNIT_DEFINES_SVH
`define DIFFUSION_STENCIL_SWEEP_UNIT_DEFINES_SVH

// same-cycle implication
`define DSS_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Widths, register codes and shared types of the diffusion stencil sweep unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

	localparam int MAX_COLS   = 2048;
	localparam int MAX_ROWS   = 2048;

	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int COLS_W     = $clog2(MAX_COLS + 1);
	localparam int ROW_W      = $clog2(MAX_ROWS + 3);

	localparam int VAL_W      = 32;
	localparam int LAP_W      = VAL_W + 3;
	localparam int GAIN_W     = 16;
	localparam int PROD_W     = GAIN_W + 1 + LAP_W;
	localparam int DELTA_W    = PROD_W - GAIN_W;
	localparam int SUMV_W     = DELTA_W + 1;
	localparam int SUM_W      = 56;

	localparam int CFG_COLS_W = 12;
	localparam int CFG_ROWS_W = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [GAIN_W-1:0]     GAIN_RESET = GAIN_W'(66);
	localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(2048);
	localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(2048);

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// queue depth must be a power of two
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN        = 2'd0,
		REG_ACTIVE_COLS = 2'd1,
		REG_ACTIVE_ROWS = 2'd2
	} dss_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [COLS_W-1:0] cols;
		logic [ROW_W-1:0]  rows;
	} dss_cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] up;
		logic signed [VAL_W-1:0] left;
		logic signed [VAL_W-1:0] mid;
		logic signed [VAL_W-1:0] right;
		logic signed [VAL_W-1:0] down;
		logic                    pass_thru;
		logic                    last;
		logic                    clr;
	} dss_work_t;

endpackage

`default_nettype wire

FILE: rtl/dss_if.sv
// ----------------------------------------------------------------------------
// dss_if
// Valid/ready stream interfaces for grid cells and for stencil results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dss_cell_if import dss_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] cell_value;
	logic                    frame_start;

	modport source (output valid, output cell_value, output frame_start, input ready);
	modport sink   (input valid, input cell_value, input frame_start, output ready);
endinterface

interface dss_result_if import dss_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] new_value;
	logic [SUM_W-1:0]        change_sum;
	logic                    last_of_sweep;

	modport source (output valid, output new_value, output change_sum,
		output last_of_sweep, input ready);
	modport sink   (input valid, input new_value, input change_sum,
		input last_of_sweep, output ready);
endinterface

`default_nettype wire

FILE: rtl/diffusion_stencil_sweep_unit.sv
// ----------------------------------------------------------------------------
// diffusion_stencil_sweep_unit
// Five-point explicit diffusion step over a raster-streamed grid.
//
//  channel   dir  handshake     payload
//  cells     in   valid/ready   cell_value, frame_start
//  results   out  valid/ready   new_value, change_sum, last_of_sweep
//  cfg       in   cfg_en        cfg_index, cfg_data
//
// One cell is taken every cycle while cells.ready is high; the line buffer read
// ports and the counter update set that rate. A result is registered in the
// front stage, the queue and each back stage before it leaves.
// A four-entry queue separates front and back; input stalls while the queue
// and the front stage together hold four items.
// Reset clears counters, queue and accumulator; line buffers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "diffusion_stencil_sweep_unit_defines.svh"

module diffusion_stencil_sweep_unit import dss_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dss_cell_if.sink                   cells,
	dss_result_if.source               results,
	input  wire logic                  cfg_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [GAIN_W-1:0]     gain_q;
	logic [CFG_COLS_W-1:0] active_cols_q;
	logic [CFG_ROWS_W-1:0] active_rows_q;

	dss_cfg_t           cfg;
	logic               q_push;
	dss_work_t          q_push_data;
	logic               q_pop;
	dss_work_t          q_pop_data;
	logic [Q_CNT_W-1:0] q_count;
	logic               q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RESET;
			active_cols_q <= COLS_RESET;
			active_rows_q <= ROWS_RESET;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_GAIN:        gain_q        <= cfg_data[GAIN_W-1:0];
				REG_ACTIVE_COLS: active_cols_q <= cfg_data[CFG_COLS_W-1:0];
				REG_ACTIVE_ROWS: active_rows_q <= cfg_data[CFG_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.gain = gain_q;
		if (active_cols_q < CFG_COLS_W'(3)) begin
			cfg.cols = COLS_W'(3);
		end else if (32'(active_cols_q) > MAX_COLS) begin
			cfg.cols = COLS_W'(MAX_COLS);
		end else begin
			cfg.cols = COLS_W'(active_cols_q);
		end
		if (active_rows_q == '0) begin
			cfg.rows = ROW_W'(1);
		end else if (32'(active_rows_q) > MAX_ROWS) begin
			cfg.rows = ROW_W'(MAX_ROWS);
		end else begin
			cfg.rows = ROW_W'(active_rows_q);
		end
	end

	dss_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cells   (cells),
		.q_count (q_count),
		.q_push  (q_push),
		.q_data  (q_push_data)
	);

	dss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.count     (q_count),
		.nonempty  (q_nonempty)
	);

	dss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gain       (cfg.gain),
		.q_data     (q_pop_data),
		.q_nonempty (q_nonempty),
		.q_pop      (q_pop),
		.results    (results)
	);

	`DSS_ASSERT_HOLDS(a_queue_no_overflow, q_push && !q_pop, q_count < Q_CNT_W'(Q_DEPTH), "queue overflow")
	`DSS_ASSERT_HOLDS(a_queue_no_underflow, q_pop, q_count != '0, "queue underflow")
	`DSS_ASSERT_NEXT(a_queue_push_lands, q_push && !q_pop, q_count != '0, "pushed item lost")
	`DSS_ASSERT_HOLDS(a_sum_only_on_last, results.valid && !results.last_of_sweep, results.change_sum == '0, "change sum off last")

endmodule

`default_nettype wire

FILE: rtl/dss_front.sv
// ----------------------------------------------------------------------------
// dss_front
// Raster position tracking, item classification and the two line buffers.
// Builds the five-point neighbourhood in the cycle after acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_front import dss_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dss_cfg_t         cfg,
	dss_cell_if.sink              cells,
	input  wire logic [Q_CNT_W-1:0] q_count,
	output logic                  q_push,
	output dss_work_t             q_data
);

	logic signed [VAL_W-1:0] upper_mem [MAX_COLS];
	logic signed [VAL_W-1:0] middle_mem [MAX_COLS];

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             clr_pend_q;
	logic signed [VAL_W-1:0] prev_mid_q;

	logic                    v_s1;
	logic                    emit_s1;
	logic                    pass_s1;
	logic                    last_s1;
	logic                    clr_s1;
	logic                    right_ok_s1;
	logic                    first_s1;
	logic [COL_W-1:0]        col_s1;
	logic signed [VAL_W-1:0] cell_s1;
	logic signed [VAL_W-1:0] up_s1;
	logic signed [VAL_W-1:0] mid_s1;
	logic signed [VAL_W-1:0] right_s1;

	logic              accept;
	logic              load;
	logic [COL_W-1:0]  col_a;
	logic [ROW_W-1:0]  row_a;
	logic [COL_W-1:0]  col_b;
	logic [ROW_W-1:0]  row_b;
	logic [COL_W-1:0]  col_r;
	logic [COLS_W-1:0] col_inc;
	logic              ignore;
	logic              emit;
	logic              last_col;
	logic              right_ok;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;

	assign cells.ready = (q_count + Q_CNT_W'(v_s1)) < Q_CNT_W'(Q_DEPTH);
	assign accept      = cells.valid && cells.ready;
	assign load        = accept && !ignore;

	always_comb begin
		col_a = cells.frame_start ? '0 : col_q;
		row_a = cells.frame_start ? '0 : row_q;
		if (COLS_W'(col_a) >= cfg.cols) begin
			col_b = '0;
			row_b = (row_a < ROW_W'(MAX_ROWS + 2)) ? row_a + ROW_W'(1) : row_a;
		end else begin
			col_b = col_a;
			row_b = row_a;
		end
		col_r    = col_b + COL_W'(1);
		col_inc  = COLS_W'(col_b) + COLS_W'(1);
		ignore   = row_b >= (cfg.rows + ROW_W'(2));
		emit     = row_b >= ROW_W'(2);
		last_col = col_inc == cfg.cols;
		right_ok = col_inc < cfg.cols;
		if (col_inc >= cfg.cols) begin
			col_n = '0;
			row_n = row_b + ROW_W'(1);
		end else begin
			col_n = col_inc[COL_W-1:0];
			row_n = row_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			clr_pend_q <= 1'b0;
			v_s1       <= 1'b0;
		end else begin
			v_s1 <= load;
			if (accept) begin
				col_q <= ignore ? col_b : col_n;
				row_q <= ignore ? row_b : row_n;
				if (cells.frame_start) begin
					clr_pend_q <= 1'b1;
				end else if (!ignore && emit) begin
					clr_pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			emit_s1     <= emit;
			pass_s1     <= (col_b == '0) || last_col;
			last_s1     <= (row_b == cfg.rows + ROW_W'(1)) && last_col;
			clr_s1      <= clr_pend_q || cells.frame_start;
			right_ok_s1 <= right_ok;
			first_s1    <= col_b == '0;
			col_s1      <= col_b;
			cell_s1     <= cells.cell_value;
		end
		if (v_s1) begin
			prev_mid_q <= mid_s1;
		end
	end

	// upper line: write back the middle value, bypass a same-address write
	always_ff @(posedge clk) begin
		if (v_s1) begin
			upper_mem[col_s1] <= mid_s1;
		end
		if (load) begin
			up_s1 <= (v_s1 && col_s1 == col_b) ? mid_s1 : upper_mem[col_b];
		end
	end

	// middle line: one write, centre and right reads
	always_ff @(posedge clk) begin
		if (v_s1) begin
			middle_mem[col_s1] <= cell_s1;
		end
		if (load) begin
			mid_s1   <= (v_s1 && col_s1 == col_b) ? cell_s1 : middle_mem[col_b];
			right_s1 <= (v_s1 && col_s1 == col_r) ? cell_s1 : middle_mem[col_r];
		end
	end

	assign q_push           = v_s1 && emit_s1;
	assign q_data.up        = up_s1;
	assign q_data.left      = first_s1 ? '0 : prev_mid_q;
	assign q_data.mid       = mid_s1;
	assign q_data.right     = right_ok_s1 ? right_s1 : '0;
	assign q_data.down      = cell_s1;
	assign q_data.pass_thru = pass_s1;
	assign q_data.last      = last_s1;
	assign q_data.clr       = clr_s1;

endmodule

`default_nettype wire

FILE: rtl/dss_queue.sv
// ----------------------------------------------------------------------------
// dss_queue
// Small register queue of neighbourhood items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_queue import dss_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire dss_work_t          push_data,
	input  wire logic               pop,
	output dss_work_t               pop_data,
	output logic [Q_CNT_W-1:0]      count,
	output logic                    nonempty
);

	dss_work_t          entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = entry_q[rd_ptr_q];
	assign count    = count_q;
	assign nonempty = count_q != '0;

endmodule

`default_nettype wire

FILE: rtl/dss_back.sv
// ----------------------------------------------------------------------------
// dss_back
// Stencil arithmetic pipeline: laplacian, gain product, rounding and
// saturation, change accumulation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_back import dss_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [GAIN_W-1:0] gain,
	input  wire dss_work_t         q_data,
	input  wire logic              q_nonempty,
	output logic                   q_pop,
	dss_result_if.source           results
);

	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic v4_q;

	logic signed [LAP_W-1:0]  lap_s1;
	logic signed [VAL_W-1:0]  mid_s1;
	logic                     pass_s1;
	logic                     last_s1;
	logic                     clr_s1;

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [VAL_W-1:0]  mid_s2;
	logic                     pass_s2;
	logic                     last_s2;
	logic                     clr_s2;

	logic signed [VAL_W-1:0]  nv_s3;
	logic signed [VAL_W:0]    diff_s3;
	logic                     pass_s3;
	logic                     last_s3;
	logic                     clr_s3;

	logic signed [VAL_W-1:0]  nv_s4;
	logic [SUM_W-1:0]         sum_s4;
	logic                     last_s4;

	logic [SUM_W-1:0]         acc_q;

	logic ld1;
	logic ld2;
	logic ld3;
	logic ld4;

	logic signed [LAP_W-1:0]   lap;
	logic signed [PROD_W-1:0]  rnd;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SUMV_W-1:0]  upd;
	logic signed [VAL_W-1:0]   sat;
	logic signed [VAL_W-1:0]   nv;
	logic [VAL_W:0]            absd;
	logic [SUM_W:0]            acc_sum;
	logic [SUM_W-1:0]          acc_nx;

	assign ld4   = v3_q && (!v4_q || results.ready);
	assign ld3   = v2_q && (!v3_q || ld4);
	assign ld2   = v1_q && (!v2_q || ld3);
	assign ld1   = q_nonempty && (!v1_q || ld2);
	assign q_pop = ld1;

	always_comb begin
		lap = LAP_W'(q_data.up) + LAP_W'(q_data.down) + LAP_W'(q_data.left)
			+ LAP_W'(q_data.right) - (LAP_W'(q_data.mid) <<< 2);
		rnd   = prod_s2 + (PROD_W'(1) << (GAIN_W - 1));
		delta = DELTA_W'(rnd >>> GAIN_W);
		upd   = SUMV_W'(mid_s2) + SUMV_W'(delta);
		if (upd > SUMV_W'(VAL_MAX)) begin
			sat = VAL_MAX;
		end else if (upd < SUMV_W'(VAL_MIN)) begin
			sat = VAL_MIN;
		end else begin
			sat = upd[VAL_W-1:0];
		end
		nv      = pass_s2 ? mid_s2 : sat;
		absd    = diff_s3[VAL_W] ? (~diff_s3 + (VAL_W+1)'(1)) : diff_s3;
		acc_sum = (SUM_W+1)'(clr_s3 ? '0 : acc_q) + (SUM_W+1)'(pass_s3 ? '0 : absd);
		acc_nx  = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q  <= 1'b0;
			v2_q  <= 1'b0;
			v3_q  <= 1'b0;
			v4_q  <= 1'b0;
			acc_q <= '0;
		end else begin
			v1_q <= ld1 || (v1_q && !ld2);
			v2_q <= ld2 || (v2_q && !ld3);
			v3_q <= ld3 || (v3_q && !ld4);
			v4_q <= ld4 || (v4_q && !results.ready);
			if (ld4) begin
				acc_q <= acc_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			lap_s1  <= lap;
			mid_s1  <= q_data.mid;
			pass_s1 <= q_data.pass_thru;
			last_s1 <= q_data.last;
			clr_s1  <= q_data.clr;
		end
		if (ld2) begin
			prod_s2 <= $signed({1'b0, gain}) * lap_s1;
			mid_s2  <= mid_s1;
			pass_s2 <= pass_s1;
			last_s2 <= last_s1;
			clr_s2  <= clr_s1;
		end
		if (ld3) begin
			nv_s3   <= nv;
			diff_s3 <= (VAL_W+1)'(nv) - (VAL_W+1)'(mid_s2);
			pass_s3 <= pass_s2;
			last_s3 <= last_s2;
			clr_s3  <= clr_s2;
		end
		if (ld4) begin
			nv_s4   <= nv_s3;
			sum_s4  <= last_s3 ? acc_nx : '0;
			last_s4 <= last_s3;
		end
	end

	assign results.valid         = v4_q;
	assign results.new_value     = nv_s4;
	assign results.change_sum    = sum_s4;
	assign results.last_of_sweep = last_s4;

endmodule

`default_nettype wire

FILE: verif/dss_tb_pkg.sv
// ----------------------------------------------------------------------------
// dss_tb_pkg
// Scoreboard for the diffusion stencil sweep unit. It tracks the line buffers,
// stream position and change sum of the block, predicts each result due from
// accepted cells and checks each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_tb_pkg;

	import dss_pkg::*;

	typedef struct {
		logic signed [VAL_W-1:0] new_value;
		logic [SUM_W-1:0]        change_sum;
		logic                    last_of_sweep;
	} cell_update_t;

	class sweep_scoreboard;

		logic [GAIN_W-1:0]       gain;
		logic [CFG_COLS_W-1:0]   cols_reg;
		logic [CFG_ROWS_W-1:0]   rows_reg;
		logic signed [VAL_W-1:0] upper_line [MAX_COLS];
		logic signed [VAL_W-1:0] middle_line [MAX_COLS];
		logic signed [VAL_W-1:0] left_cell;
		int unsigned             col_pos;
		int unsigned             row_pos;
		logic [SUM_W-1:0]        change_total;
		cell_update_t            pending_updates [$];
		int                      mismatches;

		function new();
			gain         = GAIN_RESET;
			cols_reg     = COLS_RESET;
			rows_reg     = ROWS_RESET;
			left_cell    = '0;
			col_pos      = 0;
			row_pos      = 0;
			change_total = '0;
			mismatches   = 0;
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
		endfunction

		function int unsigned eff_cols();
			if (cols_reg < 3) return 3;
			if (cols_reg > MAX_COLS) return MAX_COLS;
			return cols_reg;
		endfunction

		function int unsigned eff_rows();
			if (rows_reg < 1) return 1;
			if (rows_reg > MAX_ROWS) return MAX_ROWS;
			return rows_reg;
		endfunction

		function void write_reg(dss_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GAIN:        gain = data[GAIN_W-1:0];
				REG_ACTIVE_COLS: cols_reg = data[CFG_COLS_W-1:0];
				REG_ACTIVE_ROWS: rows_reg = data[CFG_ROWS_W-1:0];
				default: ;
			endcase
		endfunction

		function bit sweep_over();
			return row_pos >= eff_rows() + 2;
		endfunction

		function bit next_is_ghost();
			int unsigned r;
			r = (col_pos >= eff_cols()) ? row_pos + 1 : row_pos;
			return r == 0 || r >= eff_rows() + 1;
		endfunction

		function logic signed [VAL_W-1:0] diffused_value(logic signed [VAL_W-1:0] up,
				logic signed [VAL_W-1:0] left, logic signed [VAL_W-1:0] mid,
				logic signed [VAL_W-1:0] right, logic signed [VAL_W-1:0] down);
			longint lap;
			longint prod;
			longint sum;
			lap  = longint'(up) + longint'(left) + longint'(right) + longint'(down)
				- 4 * longint'(mid);
			prod = longint'(gain) * lap;
			sum  = longint'(mid) + ((prod + 64'sd32768) >>> 16);
			if (sum > longint'(VAL_MAX)) return VAL_MAX;
			if (sum < longint'(VAL_MIN)) return VAL_MIN;
			return VAL_W'(sum);
		endfunction

		function void note_cell(logic signed [VAL_W-1:0] cell_val, logic frame_start);
			int unsigned             cols;
			int unsigned             rows;
			int unsigned             c;
			logic signed [VAL_W-1:0] up;
			logic signed [VAL_W-1:0] mid;
			logic signed [VAL_W-1:0] left;
			logic signed [VAL_W-1:0] right;
			logic [SUM_W:0]          total;
			longint                  d;
			cell_update_t            upd;
			cols = eff_cols();
			rows = eff_rows();
			if (frame_start) begin
				col_pos      = 0;
				row_pos      = 0;
				change_total = '0;
			end
			// a narrowed row ends at once
			if (col_pos >= cols) begin
				col_pos = 0;
				if (row_pos < MAX_ROWS + 2) row_pos++;
			end
			if (row_pos >= rows + 2) return;
			c     = col_pos;
			up    = upper_line[c];
			mid   = middle_line[c];
			right = (c + 1 < cols) ? middle_line[c + 1] : '0;
			left  = (c > 0) ? left_cell : '0;
			if (row_pos >= 2) begin
				if (c == 0 || c == cols - 1) begin
					upd.new_value = mid;
				end else begin
					upd.new_value = diffused_value(up, left, mid, right, cell_val);
					d = longint'(upd.new_value) - longint'(mid);
					if (d < 0) d = -d;
					total = {1'b0, change_total} + (SUM_W+1)'(d);
					change_total = total[SUM_W] ? '1 : total[SUM_W-1:0];
				end
				upd.last_of_sweep = (row_pos == rows + 1) && (c == cols - 1);
				upd.change_sum    = upd.last_of_sweep ? change_total : '0;
				pending_updates.push_back(upd);
			end
			upper_line[c]  = mid;
			middle_line[c] = cell_val;
			left_cell      = mid;
			col_pos++;
			if (col_pos >= cols) begin
				col_pos = 0;
				row_pos++;
			end
		endfunction

		function void flag(string what, logic [SUM_W-1:0] exp_val, logic [SUM_W-1:0] got_val);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %h, got %h", what, exp_val, got_val);
		endfunction

		function void check_result(logic signed [VAL_W-1:0] new_value,
				logic [SUM_W-1:0] change_sum, logic last_of_sweep);
			cell_update_t upd;
			if (pending_updates.size() == 0) begin
				flag("result with none pending", '0, SUM_W'(new_value));
				return;
			end
			upd = pending_updates.pop_front();
			if (new_value !== upd.new_value)
				flag("new_value", SUM_W'(upd.new_value), SUM_W'(new_value));
			if (change_sum !== upd.change_sum)
				flag("change_sum", upd.change_sum, change_sum);
			if (last_of_sweep !== upd.last_of_sweep)
				flag("last_of_sweep", SUM_W'(upd.last_of_sweep), SUM_W'(last_of_sweep));
		endfunction

	endclass

endpackage

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams grids through the diffusion stencil sweep unit: a short set of
// corner-value grids, restarts partway into the widest and the tallest grid,
// then random small sweeps with register changes, restarts, narrowed rows and
// stray cells after the sweep. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import dss_pkg::*;
	import dss_tb_pkg::*;

	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_ITEMS = 950;
	localparam int CALM_ITEMS   = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dss_cell_if   cells();
	dss_result_if results();

	diffusion_stencil_sweep_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cells     (cells),
		.results   (results),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sweep_scoreboard sb;
	int              src_idle_pct;
	int              snk_idle_pct;
	int              cells_swept;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cells.valid && cells.ready)
				sb.note_cell(cells.cell_value, cells.frame_start);
			if (results.valid && results.ready)
				sb.check_result(results.new_value, results.change_sum, results.last_of_sweep);
		end
	end

	initial begin
		results.ready = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 99) < snk_idle_pct) begin
				results.ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			results.ready = 1'b1;
			@(negedge clk);
		end
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic signed [VAL_W-1:0] pick_value(bit ghost);
		logic signed [VAL_W-1:0] v;
		if (ghost && $urandom_range(0, 7) != 0) return '0;
		case ($urandom_range(0, 9))
			0:       v = VAL_MAX;
			1:       v = VAL_MIN;
			2, 3:    v = $urandom;
			4, 5:    v = $urandom_range(0, 8191) - 4096;
			default: v = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
		endcase
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return GAIN_RESET;
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(dss_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_en    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(negedge clk);
		cfg_en    = 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic settle();
		while (sb.pending_updates.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_cell(logic signed [VAL_W-1:0] v, logic fs);
		if ($urandom_range(0, 99) < src_idle_pct)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		cells.valid       = 1'b1;
		cells.cell_value  = v;
		cells.frame_start = fs;
		@(posedge clk);
		while (!cells.ready) @(posedge clk);
		@(negedge clk);
		cells.valid = 1'b0;
	endtask

	// abort_at: restart the grid after that many cells; cfg_at: change a
	// register mid-sweep, narrowing the row only
	task automatic run_sweep(int abort_at, int cfg_at);
		int n;
		push_cell(pick_value(1'b1), 1'b1);
		cells_swept++;
		n = 1;
		while (!sb.sweep_over() && n != abort_at) begin
			if (n == cfg_at) begin
				settle();
				case ($urandom_range(0, 2))
					0:       write_reg(REG_GAIN, pick_gain());
					1:       write_reg(REG_ACTIVE_ROWS, CFG_DATA_W'($urandom_range(0, 6)));
					default: write_reg(REG_ACTIVE_COLS,
						CFG_DATA_W'($urandom_range(0, sb.eff_cols())));
				endcase
			end
			if (!sb.sweep_over()) begin
				push_cell(pick_value(sb.next_is_ghost()), 1'b0);
				cells_swept++;
				n++;
			end
		end
	endtask

	task automatic phase_config();
		logic [CFG_DATA_W-1:0] d;
		if ($urandom_range(0, 1)) write_reg(REG_GAIN, pick_gain());
		if ($urandom_range(0, 2) != 0) begin
			d = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(13, 64))
				: CFG_DATA_W'($urandom_range(0, 12));
			if ($urandom_range(0, 9) == 0)
				d[CFG_DATA_W-1:CFG_COLS_W] = (CFG_DATA_W-CFG_COLS_W)'($urandom_range(1, 15));
			write_reg(REG_ACTIVE_COLS, d);
		end
		if ($urandom_range(0, 2) != 0) begin
			d = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(6, 20))
				: CFG_DATA_W'($urandom_range(0, 5));
			if ($urandom_range(0, 9) == 0)
				d[CFG_DATA_W-1:CFG_ROWS_W] = (CFG_DATA_W-CFG_ROWS_W)'($urandom_range(1, 15));
			write_reg(REG_ACTIVE_ROWS, d);
		end
	endtask

	task automatic random_phase();
		int abort_at;
		int cfg_at;
		settle();
		phase_config();
		abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : 0;
		cfg_at   = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 40) : 0;
		run_sweep(abort_at, cfg_at);
		if (sb.sweep_over() && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) push_cell(pick_value(1'b0), 1'b0);
	endtask

	initial begin
		logic signed [VAL_W-1:0] corner_grid [9];
		int                      base;
		arst_n            = 1'b0;
		cfg_en            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		cells.valid       = 1'b0;
		cells.cell_value  = '0;
		cells.frame_start = 1'b0;
		src_idle_pct      = 0;
		snk_idle_pct      = 0;
		cells_swept       = 0;
		sb                = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner values, ghost rows included, saturating both ways
		corner_grid = '{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
			VAL_MAX, VAL_MIN, VAL_MAX};
		write_reg(REG_GAIN, '1);
		write_reg(REG_ACTIVE_COLS, CFG_DATA_W'(3));
		write_reg(REG_ACTIVE_ROWS, CFG_DATA_W'(1));
		for (int i = 0; i < 9; i++) push_cell(corner_grid[i], i == 0);
		push_cell(VAL_MAX, 1'b0);
		push_cell(VAL_MIN, 1'b0);
		settle();
		write_reg(REG_GAIN, 16'h8000);
		for (int i = 0; i < 4; i++) push_cell(~corner_grid[i], i == 0);
		for (int i = 0; i < 9; i++) push_cell(~corner_grid[i], i == 0);
		settle();

		// widest and tallest grids, restarted partway
		src_idle_pct = 10;
		snk_idle_pct = 10;
		write_reg(REG_GAIN, pick_gain());
		write_reg(REG_ACTIVE_COLS, CFG_DATA_W'(4095));
		run_sweep($urandom_range(20, 80), 0);
		settle();
		write_reg(REG_ACTIVE_COLS, CFG_DATA_W'(MAX_COLS));
		write_reg(REG_ACTIVE_ROWS, CFG_DATA_W'(1));
		run_sweep($urandom_range(2, 40), 0);
		settle();
		write_reg(REG_ACTIVE_COLS, CFG_DATA_W'(3));
		write_reg(REG_ACTIVE_ROWS, CFG_DATA_W'(MAX_ROWS));
		run_sweep($urandom_range(20, 80), 0);
		settle();
		write_reg(REG_ACTIVE_ROWS, CFG_DATA_W'(4095));
		run_sweep($urandom_range(4, 60), 0);

		base = cells_swept;
		while (cells_swept - base < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       src_idle_pct = 0;
				1:       src_idle_pct = 15;
				default: src_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0:       snk_idle_pct = 0;
				1:       snk_idle_pct = 15;
				default: snk_idle_pct = 40;
			endcase
			random_phase();
		end

		src_idle_pct = 0;
		snk_idle_pct = 0;
		base = cells_swept;
		while (cells_swept - base < CALM_ITEMS) random_phase();

		settle();
		if (sb.mismatches == 0 && sb.pending_updates.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
